/* src/vgs_pkg.sv */
// Package for the voxel grid sampler: sizes, field types and helpers.
// Used by every module under src.
package vgs_pkg;
    localparam int DEPTH_X = 32;
    localparam int DEPTH_Y = 32;
    localparam int DEPTH_Z = 32;
    localparam int XW = $clog2(DEPTH_X);
    localparam int YW = $clog2(DEPTH_Y);
    localparam int ZW = $clog2(DEPTH_Z);
    localparam int AW = XW + YW + ZW;
    localparam int DEPTH = DEPTH_X * DEPTH_Y * DEPTH_Z;
    localparam int QDEPTH = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_INV   = 3'd3;
    localparam logic [2:0] REG_LEN_X = 3'd4;
    localparam logic [2:0] REG_LEN_Y = 3'd5;
    localparam logic [2:0] REG_LEN_Z = 3'd6;
    localparam logic [2:0] REG_MODE  = 3'd7;

    // Classified work handed from front to back
    typedef struct packed {
        logic          is_load;
        logic          trilin;
        logic          valid;
        logic [XW-1:0] ix;
        logic [YW-1:0] iy;
        logic [ZW-1:0] iz;
        logic [7:0]    wx;
        logic [7:0]    wy;
        logic [7:0]    wz;
        logic [15:0]   measure;
    } t_job;

    function automatic logic [AW-1:0] vaddr(logic [XW-1:0] x, logic [YW-1:0] y,
                                            logic [ZW-1:0] z);
        return {x, y, z};
    endfunction
endpackage

/* src/vgs_front.sv */
// Front part: quantizes one axis per cycle and classifies the item.
// Depends on vgs_pkg.
module vgs_front import vgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [15:0] i_cx,
    input  logic [15:0] i_cy,
    input  logic [15:0] i_cz,
    input  logic [15:0] i_measure,
    input  logic [15:0] i_org_x,
    input  logic [15:0] i_org_y,
    input  logic [15:0] i_org_z,
    input  logic [15:0] i_inv,
    input  logic [5:0]  i_len_x,
    input  logic [5:0]  i_len_y,
    input  logic [5:0]  i_len_z,
    input  logic        i_mode,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AX   = 3'd1;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_st, n_st;
    logic [1:0]  r_axis;
    logic [15:0] r_c [3];
    logic        r_op;
    logic [15:0] r_meas;
    logic        r_ok;
    logic [8:0]  r_idx [3];
    logic [7:0]  r_w [3];

    logic signed [16:0] diff;
    logic signed [34:0] t;
    logic [15:0] org;
    logic [5:0]  len;
    logic [8:0]  ext, lim;
    logic        trilin;
    logic        ax_ok;

    assign trilin = (r_op == OP_QUERY) && i_mode;

    // Pick axis operands
    always_comb begin
        unique case (r_axis)
            2'd0:    begin org = i_org_x; len = i_len_x; end
            2'd1:    begin org = i_org_y; len = i_len_y; end
            default: begin org = i_org_z; len = i_len_z; end
        endcase
    end

    localparam logic [8:0] DXL = 9'(DEPTH_X);
    localparam logic [8:0] DYL = 9'(DEPTH_Y);
    localparam logic [8:0] DZL = 9'(DEPTH_Z);

    // Quantize the current axis
    always_comb begin
        logic [8:0] dep;
        unique case (r_axis)
            2'd0:    dep = DXL;
            2'd1:    dep = DYL;
            default: dep = DZL;
        endcase
        diff = 17'(signed'(r_c[r_axis])) - 17'(signed'(org));
        t = 35'(diff) * 35'(signed'({1'b0, i_inv})) + 35'sd131072;
        ext = ({3'd0, len} < dep) ? {3'd0, len} : dep;
        lim = trilin ? 9'(t[34:18] + 17'd1) : 9'(t[34:18]);
        ax_ok = !t[34] && (t[34:26] == 9'd0 || (t[33:18] < 16'(ext)))
                && (t[33:26] == 8'd0) && (lim < ext);
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_job_valid = (r_st == S_OUT);

    always_comb begin
        o_job.is_load = (r_op == OP_LOAD);
        o_job.trilin  = trilin;
        o_job.valid   = r_ok;
        o_job.ix      = r_idx[0][XW-1:0];
        o_job.iy      = r_idx[1][YW-1:0];
        o_job.iz      = r_idx[2][ZW-1:0];
        o_job.wx      = r_w[0];
        o_job.wy      = r_w[1];
        o_job.wz      = r_w[2];
        o_job.measure = r_meas;
    end

    // Sequence the axes
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_valid) n_st = S_AX;
            S_AX:    if (r_axis == 2'd2) n_st = S_OUT;
            S_OUT:   if (i_job_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_axis <= 2'd0;
        end else begin
            r_st <= n_st;
            if (r_st == S_IDLE) r_axis <= 2'd0;
            else if (r_st == S_AX) r_axis <= r_axis + 2'd1;
        end
    end

    // Capture the item and the per-axis results
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_valid) begin
            r_c[0] <= i_cx;
            r_c[1] <= i_cy;
            r_c[2] <= i_cz;
            r_op   <= i_op;
            r_meas <= i_measure;
            r_ok   <= 1'b1;
        end else if (r_st == S_AX) begin
            r_idx[r_axis] <= 9'(t[34:18]);
            r_w[r_axis]   <= t[17:10];
            r_ok          <= r_ok & ax_ok;
        end
    end
endmodule

/* src/vgs_queue.sv */
// Short job queue between front and back parts.
// Depends on vgs_pkg.
module vgs_queue import vgs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    localparam int PW = $clog2(QDEPTH);
    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != (PW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule

/* src/vgs_back.sv */
// Back part: voxel memory, clearing pass, corner reads and blend.
// Depends on vgs_pkg.
module vgs_back import vgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_job        i_job,
    output logic        o_clearing,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_value,
    output logic        o_in_range
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_RND  = 4'd5;
    localparam logic [3:0] S_OUT  = 4'd6;

    logic [15:0]  r_mem [DEPTH];
    logic [15:0]  r_rdata;
    logic [3:0]   r_st;
    logic [AW:0]  r_clr;
    t_job         r_job;
    logic [3:0]   r_c;
    logic [2:0]   r_cc;
    logic [16:0]  r_wxy;
    logic [24:0]  r_prod;
    logic [40:0]  r_acc;
    logic [15:0]  r_val;
    logic         r_rng;

    logic [2:0]   cn;
    logic [AW-1:0] raddr;
    logic [8:0]   fx, fy, fz;
    logic [40:0]  rnd;

    assign o_clearing = (r_st == S_CLR);
    assign o_ready    = (r_st == S_IDLE);
    assign o_valid    = (r_st == S_OUT);
    assign o_value    = r_val;
    assign o_in_range = r_rng;

    assign cn = r_c[2:0];
    assign raddr = vaddr(r_job.ix + XW'(cn[0] & r_job.trilin),
                         r_job.iy + YW'(cn[1] & r_job.trilin),
                         r_job.iz + ZW'(cn[2] & r_job.trilin));
    assign fx = r_cc[0] ? {1'b0, r_job.wx} : 9'd256 - {1'b0, r_job.wx};
    assign fy = r_cc[1] ? {1'b0, r_job.wy} : 9'd256 - {1'b0, r_job.wy};
    assign fz = r_cc[2] ? {1'b0, r_job.wz} : 9'd256 - {1'b0, r_job.wz};

    // Round the 24 fraction bit sum half up
    assign rnd = r_acc + 41'd8388608;

    // Memory: clear sweep, load write, registered read
    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR)
            r_mem[r_clr[AW-1:0]] <= '0;
        else if (r_st == S_RD && r_job.is_load && r_job.valid)
            r_mem[raddr] <= r_job.measure;
        r_rdata <= r_mem[raddr];
    end

    // Sequence: read corner c, then multiply by weights and accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_clr <= '0;
        end else begin
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(DEPTH - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_valid) r_st <= S_RD;
                S_RD: begin
                    if (r_job.is_load || !r_job.valid) r_st <= S_OUT;
                    else r_st <= S_MUL;
                end
                S_MUL: r_st <= S_ACC;
                S_ACC: begin
                    if (!r_job.trilin || r_cc == 3'd7) r_st <= S_RND;
                    else r_st <= S_MUL;
                end
                S_RND: r_st <= S_OUT;
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // Datapath registers; advance to the next corner once its product is summed
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_job <= i_job;
                r_c   <= '0;
                r_acc <= '0;
            end
            S_RD: begin
                r_cc  <= cn;
                r_c   <= r_c + 4'd1;
                r_val <= 16'd0;
                r_rng <= r_job.valid;
            end
            S_MUL: begin
                r_wxy  <= 17'(18'(fx) * 18'(fy));
                r_prod <= 25'(r_rdata) * 25'(fz);
            end
            S_ACC: begin
                r_acc <= r_acc + 41'(r_wxy) * 41'(r_prod);
                r_cc  <= cn;
                r_c   <= r_c + 4'd1;
            end
            S_RND: begin
                if (!r_job.trilin)
                    r_val <= r_rdata;
                else
                    r_val <= rnd[40] ? 16'hFFFF : rnd[39:24];
            end
            default: ;
        endcase
    end
endmodule

/* src/voxel_grid_sampler.sv */
// Voxel grid sampler top level: APB registers, front, queue and back parts.
// Depends on vgs_pkg, vgs_front, vgs_queue, vgs_back.
//
//  channel   dir  fields (tdata/tuser from bit 0)
//  s_axis    in   tdata: coord_x, coord_y, coord_z, measure_in; tuser: op
//  m_axis    out  tdata: sample_value; tuser: in_range
//  apb       in   registers at 4*i, i = 0..7
//
// The front quantizes the three axes of an item in turn and takes no new item until
// it has handed its job on; the back likewise works on one item at a time. A load
// writes the voxel memory; a nearest query reads one corner and a trilinear query
// eight, each read followed by a multiply and an accumulate step, then rounding.
// After reset a clearing pass zeroes all DEPTH (32768) words of the memory;
// no item is taken meanwhile. Front and back stall independently.
module voxel_grid_sampler import vgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // coord_x, coord_y, coord_z, measure_in
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // sample_value
    output logic        m_axis_tuser,   // in_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] r_org_x, r_org_y, r_org_z, r_inv;
    logic [5:0]  r_len_x, r_len_y, r_len_z;
    logic        r_mode;
    logic [2:0]  ridx;
    logic        wr;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign wr     = psel && penable && pwrite;

    // Register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0; r_org_y <= '0; r_org_z <= '0;
            r_inv   <= 16'd5120;
            r_len_x <= 6'd32; r_len_y <= 6'd32; r_len_z <= 6'd32;
            r_mode  <= 1'b0;
        end else if (wr) begin
            unique case (ridx)
                REG_ORG_X: r_org_x <= pwdata[15:0];
                REG_ORG_Y: r_org_y <= pwdata[15:0];
                REG_ORG_Z: r_org_z <= pwdata[15:0];
                REG_INV:   r_inv   <= pwdata[15:0];
                REG_LEN_X: r_len_x <= pwdata[5:0];
                REG_LEN_Y: r_len_y <= pwdata[5:0];
                REG_LEN_Z: r_len_z <= pwdata[5:0];
                REG_MODE:  r_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (ridx)
            REG_ORG_X: prdata = {16'd0, r_org_x};
            REG_ORG_Y: prdata = {16'd0, r_org_y};
            REG_ORG_Z: prdata = {16'd0, r_org_z};
            REG_INV:   prdata = {16'd0, r_inv};
            REG_LEN_X: prdata = {26'd0, r_len_x};
            REG_LEN_Y: prdata = {26'd0, r_len_y};
            REG_LEN_Z: prdata = {26'd0, r_len_z};
            default:   prdata = {31'd0, r_mode};
        endcase
    end

    logic f_valid, f_ready, b_valid, b_ready, clearing, fr_ready;
    t_job f_job, b_job;

    assign s_axis_tready = fr_ready && !clearing;

    vgs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid && !clearing), .o_ready(fr_ready),
        .i_op(s_axis_tuser), .i_cx(s_axis_tdata[15:0]), .i_cy(s_axis_tdata[31:16]),
        .i_cz(s_axis_tdata[47:32]), .i_measure(s_axis_tdata[63:48]),
        .i_org_x(r_org_x), .i_org_y(r_org_y), .i_org_z(r_org_z), .i_inv(r_inv),
        .i_len_x(r_len_x), .i_len_y(r_len_y), .i_len_z(r_len_z), .i_mode(r_mode),
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job)
    );

    vgs_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(b_valid), .i_ready(b_ready), .o_job(b_job)
    );

    vgs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(b_valid), .o_ready(b_ready), .i_job(b_job),
        .o_clearing(clearing),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(m_axis_tdata), .o_in_range(m_axis_tuser)
    );
endmodule
